### sv/sbee_pkg.sv
// Shared types, codes and character helpers for the string-build escape expander.
// Used by sbee_decode, sbee_result_buf and string_build_escape_expander.
package sbee_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CARET_LITERAL = 2'd0;
    localparam logic [1:0] CFG_INITIAL_CASE  = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH    = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

    // Case modes
    localparam logic [1:0] CASE_NONE  = 2'd0;
    localparam logic [1:0] CASE_LOWER = 2'd1;
    localparam logic [1:0] CASE_UPPER = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_QTEXT  = 3'd1;
    localparam logic [2:0] KIND_QNUM   = 3'd2;
    localparam logic [2:0] KIND_FSPEC  = 3'd3;
    localparam logic [2:0] KIND_SEARCH = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_ILL_STRING = 2'd0;
    localparam logic [1:0] ERR_ILL_CARET  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG   = 2'd2;
    localparam logic [1:0] ERR_ILL_E      = 2'd3;

    // Characters
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_US      = 8'h5F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_Q_UP    = 8'h51;
    localparam logic [7:0] CH_Q_LOW   = 8'h71;
    localparam logic [7:0] CH_U_UP    = 8'h55;
    localparam logic [7:0] CH_U_LOW   = 8'h75;
    localparam logic [7:0] CTRL_MASK  = 8'h3F;
    localparam logic [7:0] CTRL_E     = 8'h05;
    localparam logic [7:0] CTRL_Q     = 8'h11;
    localparam logic [7:0] CTRL_R     = 8'h12;
    localparam logic [7:0] CTRL_V     = 8'h16;
    localparam logic [7:0] CTRL_W     = 8'h17;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CARET,
        ST_LIT,
        ST_VW,
        ST_VWCARET,
        ST_E,
        ST_EQ,
        ST_EU
    } prefix_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_char;
    } sbee_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [1:0]  err_code;
        logic [15:0] built_length;
        logic        last_result;
    } sbee_res_t;

    typedef struct packed {
        logic        caret_literal;
        logic [1:0]  initial_case;
        logic [15:0] max_length;
    } sbee_cfg_t;

    typedef struct packed {
        prefix_t     prefix;
        logic [1:0]  case_mode;
        logic        vw_is_upper;
        logic [15:0] out_count;
        logic        failed;
        logic        in_string;
    } sbee_state_t;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] low_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic sbee_res_t make_res(input logic [2:0] kind, input logic [7:0] value,
                                           input logic [1:0] code, input logic [15:0] len,
                                           input logic last);
        sbee_res_t r;
        r.kind         = kind;
        r.value        = value;
        r.err_code     = code;
        r.built_length = len;
        r.last_result  = last;
        return r;
    endfunction

endpackage

### sv/sbee_decode.sv
// Single-pass decode of one character: next per-string state and up to three results.
// Depends on sbee_pkg.
module sbee_decode (
    input  sbee_pkg::sbee_in_t    item,
    input  sbee_pkg::sbee_cfg_t   cfg,
    input  sbee_pkg::sbee_state_t cur,
    output sbee_pkg::sbee_state_t nxt,
    output sbee_pkg::sbee_res_t   res [sbee_pkg::MAX_RESULTS],
    output logic [1:0]            res_count
);

    sbee_pkg::prefix_t   st;
    logic [1:0]          cm;
    logic                vwu;
    logic [15:0]         cnt;
    logic                fl;
    logic [1:0]          n;
    sbee_pkg::sbee_res_t res_arr [sbee_pkg::MAX_RESULTS];

    logic [7:0] ch;
    logic [7:0] up_ch;
    logic [7:0] dec_t;
    logic       caret_ok;
    logic       caret_start;

    logic       do_disp;
    logic [7:0] disp_t;
    logic       do_fvw;
    logic [7:0] fvw_t;
    logic       caret_bad;
    logic       ins_v;
    logic [2:0] ins_kind;
    logic       emit_a;
    logic [7:0] a_ch;
    logic       emit_b;

    assign ch          = item.ch;
    assign up_ch       = sbee_pkg::up_case(ch);
    assign caret_ok    = (up_ch >= sbee_pkg::CH_AT) && (up_ch <= sbee_pkg::CH_US);
    assign dec_t       = up_ch & sbee_pkg::CTRL_MASK;
    assign caret_start = (ch == sbee_pkg::CH_CARET) && !cfg.caret_literal;

    always_comb
    begin
        st  = cur.prefix;
        cm  = cur.in_string ? cur.case_mode : cfg.initial_case;
        vwu = cur.vw_is_upper;
        cnt = cur.out_count;
        fl  = cur.failed;
        n   = 2'd0;
        for (int i = 0; i < sbee_pkg::MAX_RESULTS; i++)
        begin
            res_arr[i] = '0;
        end

        do_disp   = 1'b0;
        disp_t    = ch;
        do_fvw    = 1'b0;
        fvw_t     = ch;
        caret_bad = 1'b0;
        ins_v     = 1'b0;
        ins_kind  = sbee_pkg::KIND_QTEXT;
        emit_a    = 1'b0;
        a_ch      = ch;
        emit_b    = 1'b0;

        if (!fl)
        begin
            case (st)
                sbee_pkg::ST_IDLE:
                begin
                    if (caret_start)
                        st = sbee_pkg::ST_CARET;
                    else
                        do_disp = 1'b1;
                end
                sbee_pkg::ST_CARET:
                begin
                    if (caret_ok)
                    begin
                        do_disp = 1'b1;
                        disp_t  = dec_t;
                    end
                    else
                        caret_bad = 1'b1;
                end
                sbee_pkg::ST_LIT:
                begin
                    st     = sbee_pkg::ST_IDLE;
                    emit_a = 1'b1;
                end
                sbee_pkg::ST_VW:
                begin
                    if (caret_start)
                        st = sbee_pkg::ST_VWCARET;
                    else
                        do_fvw = 1'b1;
                end
                sbee_pkg::ST_VWCARET:
                begin
                    if (caret_ok)
                    begin
                        do_fvw = 1'b1;
                        fvw_t  = dec_t;
                    end
                    else
                        caret_bad = 1'b1;
                end
                sbee_pkg::ST_E:
                begin
                    if (ch == sbee_pkg::CH_Q_UP || ch == sbee_pkg::CH_Q_LOW)
                        st = sbee_pkg::ST_EQ;
                    else if (ch == sbee_pkg::CH_U_UP || ch == sbee_pkg::CH_U_LOW)
                        st = sbee_pkg::ST_EU;
                    else
                    begin
                        // unknown ^E construct: emit ^E, then the character
                        st     = sbee_pkg::ST_IDLE;
                        emit_a = 1'b1;
                        a_ch   = sbee_pkg::CTRL_E;
                        emit_b = 1'b1;
                    end
                end
                sbee_pkg::ST_EQ:
                begin
                    st    = sbee_pkg::ST_IDLE;
                    ins_v = 1'b1;
                    if (ch == sbee_pkg::CH_STAR)
                        ins_kind = sbee_pkg::KIND_FSPEC;
                    else if (ch == sbee_pkg::CH_US)
                        ins_kind = sbee_pkg::KIND_SEARCH;
                    else
                        ins_kind = sbee_pkg::KIND_QTEXT;
                end
                sbee_pkg::ST_EU:
                begin
                    st       = sbee_pkg::ST_IDLE;
                    ins_v    = 1'b1;
                    ins_kind = sbee_pkg::KIND_QNUM;
                end
                default:
                    st = sbee_pkg::ST_IDLE;
            endcase
        end

        if (do_disp)
        begin
            st = sbee_pkg::ST_IDLE;
            case (disp_t)
                sbee_pkg::CTRL_Q, sbee_pkg::CTRL_R:
                    st = sbee_pkg::ST_LIT;
                sbee_pkg::CTRL_V:
                begin
                    st  = sbee_pkg::ST_VW;
                    vwu = 1'b0;
                end
                sbee_pkg::CTRL_W:
                begin
                    st  = sbee_pkg::ST_VW;
                    vwu = 1'b1;
                end
                sbee_pkg::CTRL_E:
                    st = sbee_pkg::ST_E;
                default:
                begin
                    emit_a = 1'b1;
                    if (cm == sbee_pkg::CASE_LOWER)
                        a_ch = sbee_pkg::low_case(disp_t);
                    else if (cm == sbee_pkg::CASE_UPPER)
                        a_ch = sbee_pkg::up_case(disp_t);
                    else
                        a_ch = disp_t;
                end
            endcase
        end

        if (do_fvw)
        begin
            st = sbee_pkg::ST_IDLE;
            if (!vwu)
            begin
                if (fvw_t == sbee_pkg::CTRL_V)
                    cm = sbee_pkg::CASE_LOWER;
                else
                begin
                    emit_a = 1'b1;
                    a_ch   = sbee_pkg::low_case(fvw_t);
                end
            end
            else
            begin
                if (fvw_t == sbee_pkg::CTRL_W)
                    cm = sbee_pkg::CASE_UPPER;
                else
                begin
                    emit_a = 1'b1;
                    a_ch   = sbee_pkg::up_case(fvw_t);
                end
            end
        end

        if (caret_bad)
        begin
            res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_ERROR, ch,
                                            sbee_pkg::ERR_ILL_CARET, cnt, 1'b0);
            n  = n + 2'd1;
            fl = 1'b1;
            st = sbee_pkg::ST_IDLE;
        end

        if (ins_v)
        begin
            res_arr[n] = sbee_pkg::make_res(ins_kind, ch, sbee_pkg::ERR_ILL_STRING,
                                            cnt, 1'b0);
            n = n + 2'd1;
        end

        if (emit_a)
        begin
            if (cnt >= cfg.max_length)
            begin
                res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_ERROR, 8'd0,
                                                sbee_pkg::ERR_TOO_LONG, cnt, 1'b0);
                fl = 1'b1;
                st = sbee_pkg::ST_IDLE;
            end
            else
            begin
                cnt        = cnt + 16'd1;
                res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_CHAR, a_ch,
                                                sbee_pkg::ERR_ILL_STRING, cnt, 1'b0);
            end
            n = n + 2'd1;
        end

        if (emit_b && !fl)
        begin
            if (cnt >= cfg.max_length)
            begin
                res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_ERROR, 8'd0,
                                                sbee_pkg::ERR_TOO_LONG, cnt, 1'b0);
                fl = 1'b1;
                st = sbee_pkg::ST_IDLE;
            end
            else
            begin
                cnt        = cnt + 16'd1;
                res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_CHAR, ch,
                                                sbee_pkg::ERR_ILL_STRING, cnt, 1'b0);
            end
            n = n + 2'd1;
        end

        if (item.final_char)
        begin
            // a construct left open by the last character is truncated
            if (!fl && st != sbee_pkg::ST_IDLE)
            begin
                res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_ERROR, 8'd0,
                                                (st == sbee_pkg::ST_E) ? sbee_pkg::ERR_ILL_E
                                                                       : sbee_pkg::ERR_ILL_STRING,
                                                cnt, 1'b0);
                n = n + 2'd1;
            end
            if (n != 2'd3)
            begin
                res_arr[n] = sbee_pkg::make_res(sbee_pkg::KIND_END, 8'd0,
                                                sbee_pkg::ERR_ILL_STRING, cnt, 1'b1);
                n = n + 2'd1;
            end
            nxt.prefix      = sbee_pkg::ST_IDLE;
            nxt.case_mode   = cfg.initial_case;
            nxt.vw_is_upper = 1'b0;
            nxt.out_count   = 16'd0;
            nxt.failed      = 1'b0;
            nxt.in_string   = 1'b0;
        end
        else
        begin
            nxt.prefix      = st;
            nxt.case_mode   = cm;
            nxt.vw_is_upper = vwu;
            nxt.out_count   = cnt;
            nxt.failed      = fl;
            nxt.in_string   = 1'b1;
        end
    end

    assign res       = res_arr;
    assign res_count = n;

endmodule

### sv/sbee_result_buf.sv
// Three-entry result buffer that shifts results out one transfer at a time.
// Depends on sbee_pkg.
module sbee_result_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [1:0]          load_count,
    input  sbee_pkg::sbee_res_t load_data [sbee_pkg::MAX_RESULTS],
    output logic                free,
    output logic                res_valid,
    input  logic                res_stall,
    output sbee_pkg::sbee_res_t res_data
);

    sbee_pkg::sbee_res_t ent_reg [sbee_pkg::MAX_RESULTS];
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                xfer;

    assign res_valid = (count_reg != 2'd0);
    assign res_data  = ent_reg[0];
    assign xfer      = res_valid && !res_stall;
    // can take a new batch when empty or the last entry leaves now
    assign free      = (count_reg == 2'd0) || (count_reg == 2'd1 && !res_stall);

    always_comb
    begin
        if (load)
            count_next = load_count;
        else if (xfer)
            count_next = count_reg - 2'd1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= load_data;
        else if (xfer)
        begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

endmodule

### sv/string_build_escape_expander.sv
// String-build escape expander: one argument character in, expanded results out.
// Channel chr carries {ch, final_char}; channel res carries one result per transfer.
// Configuration is a plain write port: cfg_we, cfg_index (0 caret_literal,
// 1 initial_case, 2 max_length), cfg_data; writes take effect at the next edge.
// A character taken into the input register is decoded and loaded as a batch into
// the result buffer. Throughput: one character per cycle while each character yields
// at most one result and res_stall is low; a character yielding more results (up to
// three) holds the input side until the single output port drains the result buffer.
// Characters that yield no result (prefixes) still pass through the input register.
// A character is held in an input register, decoded in one pass against the
// per-string state and written as a batch into a three-entry result buffer.
// The next character is taken while results wait; chr_stall rises only when
// the held character cannot enter the buffer.
// Reset clears the state, the buffer and the registers to their defaults
// (caret_literal 0, initial_case 0, max_length 1024).
// A stalled receiver holds res_data stable and backs up into chr_stall.
// Depends on sbee_pkg, sbee_decode, sbee_result_buf.
module string_build_escape_expander (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              chr_valid,
    output logic                              chr_stall,
    input  sbee_pkg::sbee_in_t                chr_data,
    output logic                              res_valid,
    input  logic                              res_stall,
    output sbee_pkg::sbee_res_t               res_data,
    input  logic                              cfg_we,
    input  logic [sbee_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sbee_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sbee_pkg::sbee_cfg_t   cfg_reg;
    sbee_pkg::sbee_state_t state_reg;
    sbee_pkg::sbee_state_t state_next;
    sbee_pkg::sbee_in_t    hold_reg;
    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    logic                  accept;
    logic                  consume;
    logic                  buf_free;
    sbee_pkg::sbee_res_t   dec_res [sbee_pkg::MAX_RESULTS];
    logic [1:0]            dec_count;

    assign consume   = hold_valid_reg && buf_free;
    assign chr_stall = hold_valid_reg && !buf_free;
    assign accept    = chr_valid && !chr_stall;

    always_comb
    begin
        if (accept)
            hold_valid_next = 1'b1;
        else if (consume)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg      <= 1'b0;
            state_reg.prefix    <= sbee_pkg::ST_IDLE;
            state_reg.case_mode <= sbee_pkg::CASE_NONE;
            state_reg.vw_is_upper <= 1'b0;
            state_reg.out_count <= 16'd0;
            state_reg.failed    <= 1'b0;
            state_reg.in_string <= 1'b0;
            cfg_reg.caret_literal <= 1'b0;
            cfg_reg.initial_case  <= sbee_pkg::CASE_NONE;
            cfg_reg.max_length    <= sbee_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (consume)
                state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sbee_pkg::CFG_CARET_LITERAL: cfg_reg.caret_literal <= cfg_data[0];
                    sbee_pkg::CFG_INITIAL_CASE:  cfg_reg.initial_case  <= cfg_data[1:0];
                    sbee_pkg::CFG_MAX_LENGTH:    cfg_reg.max_length    <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= chr_data;
    end

    sbee_decode u_decode (
        .item      (hold_reg),
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (dec_res),
        .res_count (dec_count)
    );

    sbee_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume),
        .load_count (dec_count),
        .load_data  (dec_res),
        .free       (buf_free),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule
